// ===== src/hc_pkg.sv =====
// Shared types, constants and mod-26 helpers for the 2x2 Hill cipher block.
package hc_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned SumW    = 11;
  localparam int unsigned QDepth  = 2;

  localparam logic [4:0] Alpha     = 5'd26;
  localparam logic [4:0] PadLetter = 5'd23;

  // Cycles that the derived key pipeline needs after a register write or reset
  localparam logic [1:0] KeySettle = 2'd3;

  // Register indexes on the configuration port
  localparam logic [2:0] RegK00     = 3'd0;
  localparam logic [2:0] RegK01     = 3'd1;
  localparam logic [2:0] RegK10     = 3'd2;
  localparam logic [2:0] RegK11     = 3'd3;
  localparam logic [2:0] RegDecrypt = 3'd4;

  typedef logic [LetterW-1:0] letter_t;

  // One letter pair waiting for the matrix product
  typedef struct packed {
    letter_t p0;
    letter_t p1;
    logic    last;
  } pair_t;

  // Matrix in use for the current mode, plus the bad-key flag
  typedef struct packed {
    letter_t e00;
    letter_t e01;
    letter_t e10;
    letter_t e11;
    logic    err;
  } key_t;

  // Reduce a 5-bit value into 0..25
  function automatic letter_t red26(input logic [4:0] v);
    letter_t r;
    if (v >= Alpha) begin
      r = v - Alpha;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Remainder mod 26 of a value below 2048, by reciprocal multiply and one fix-up
  function automatic letter_t mod26(input logic [SumW-1:0] s);
    logic [22:0]     prod;
    logic [6:0]      q;
    logic [SumW-1:0] r;
    prod = {12'd0, s} * 23'd2521;
    q    = prod[22:16];
    r    = s - SumW'({4'd0, q} * SumW'(Alpha));
    if (r >= SumW'(Alpha)) begin
      r = r - SumW'(Alpha);
    end
    return r[LetterW-1:0];
  endfunction

  // Multiplicative inverse mod 26: {ok, inverse}
  function automatic logic [5:0] inv26(input letter_t d);
    logic [5:0] r;
    case (d)
      5'd1:    r = {1'b1, 5'd1};
      5'd3:    r = {1'b1, 5'd9};
      5'd5:    r = {1'b1, 5'd21};
      5'd7:    r = {1'b1, 5'd15};
      5'd9:    r = {1'b1, 5'd3};
      5'd11:   r = {1'b1, 5'd19};
      5'd15:   r = {1'b1, 5'd7};
      5'd17:   r = {1'b1, 5'd23};
      5'd19:   r = {1'b1, 5'd11};
      5'd21:   r = {1'b1, 5'd5};
      5'd23:   r = {1'b1, 5'd17};
      5'd25:   r = {1'b1, 5'd25};
      default: r = {1'b0, 5'd0};
    endcase
    return r;
  endfunction

endpackage

// ===== src/hc_key.sv =====
// Key registers on the APB port and the pipeline that derives the active matrix.
module hc_key (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output hc_pkg::key_t  key_o,
  output logic          busy_o
);

  logic [4:0] k00_q, k01_q, k10_q, k11_q;
  logic       dec_q;
  logic [2:0] idx;
  logic       wr_en;
  logic [1:0] settle_q, settle_d;

  // Stage A: reduced elements and determinant products
  hc_pkg::letter_t a00_q, a01_q, a10_q, a11_q;
  logic [9:0]      pa_q, pb_q;
  logic            a_dec_q;
  // Stage B: determinant inverse
  hc_pkg::letter_t b00_q, b01_q, b10_q, b11_q;
  hc_pkg::letter_t b_id_q;
  logic            b_ok_q, b_dec_q;
  hc_pkg::letter_t det_pa, det_pb, det;
  logic [5:0]      inv_res;
  // Stage C: active matrix
  hc_pkg::key_t    key_q, key_d;
  hc_pkg::letter_t neg01, neg10;

  assign idx   = paddr[4:2];
  assign wr_en = psel & penable & pwrite;

  // Write key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k00_q <= 5'd9;
      k01_q <= 5'd4;
      k10_q <= 5'd5;
      k11_q <= 5'd7;
      dec_q <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        hc_pkg::RegK00:     k00_q <= pwdata[4:0];
        hc_pkg::RegK01:     k01_q <= pwdata[4:0];
        hc_pkg::RegK10:     k10_q <= pwdata[4:0];
        hc_pkg::RegK11:     k11_q <= pwdata[4:0];
        hc_pkg::RegDecrypt: dec_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      hc_pkg::RegK00:     prdata = {27'd0, k00_q};
      hc_pkg::RegK01:     prdata = {27'd0, k01_q};
      hc_pkg::RegK10:     prdata = {27'd0, k10_q};
      hc_pkg::RegK11:     prdata = {27'd0, k11_q};
      hc_pkg::RegDecrypt: prdata = {31'd0, dec_q};
      default:            prdata = 32'd0;
    endcase
  end

  // Hold off items until the derived matrix has caught up
  always_comb begin
    settle_d = settle_q;
    if (wr_en) begin
      settle_d = hc_pkg::KeySettle;
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= hc_pkg::KeySettle;
    end else begin
      settle_q <= settle_d;
    end
  end

  assign busy_o = (settle_q != 2'd0);

  // Stage A
  always_ff @(posedge clk_i) begin
    a00_q   <= hc_pkg::red26(k00_q);
    a01_q   <= hc_pkg::red26(k01_q);
    a10_q   <= hc_pkg::red26(k10_q);
    a11_q   <= hc_pkg::red26(k11_q);
    pa_q    <= {5'd0, hc_pkg::red26(k00_q)} * {5'd0, hc_pkg::red26(k11_q)};
    pb_q    <= {5'd0, hc_pkg::red26(k01_q)} * {5'd0, hc_pkg::red26(k10_q)};
    a_dec_q <= dec_q;
  end

  // Determinant mod 26 and its inverse
  always_comb begin
    det_pa = hc_pkg::mod26({1'b0, pa_q});
    det_pb = hc_pkg::mod26({1'b0, pb_q});
    if (det_pa >= det_pb) begin
      det = det_pa - det_pb;
    end else begin
      det = det_pa + hc_pkg::Alpha - det_pb;
    end
    inv_res = hc_pkg::inv26(det);
  end

  // Stage B
  always_ff @(posedge clk_i) begin
    b00_q   <= a00_q;
    b01_q   <= a01_q;
    b10_q   <= a10_q;
    b11_q   <= a11_q;
    b_id_q  <= inv_res[4:0];
    b_ok_q  <= inv_res[5];
    b_dec_q <= a_dec_q;
  end

  // Pick the key or its inverse; a bad key in decrypt mode yields an all-zero matrix
  always_comb begin
    neg01 = (b01_q == 5'd0) ? 5'd0 : hc_pkg::Alpha - b01_q;
    neg10 = (b10_q == 5'd0) ? 5'd0 : hc_pkg::Alpha - b10_q;
    if (!b_dec_q) begin
      key_d = '{e00: b00_q, e01: b01_q, e10: b10_q, e11: b11_q, err: 1'b0};
    end else if (!b_ok_q) begin
      key_d = '{e00: 5'd0, e01: 5'd0, e10: 5'd0, e11: 5'd0, err: 1'b1};
    end else begin
      key_d.e00 = hc_pkg::mod26({1'b0, {5'd0, b11_q} * {5'd0, b_id_q}});
      key_d.e01 = hc_pkg::mod26({1'b0, {5'd0, neg01} * {5'd0, b_id_q}});
      key_d.e10 = hc_pkg::mod26({1'b0, {5'd0, neg10} * {5'd0, b_id_q}});
      key_d.e11 = hc_pkg::mod26({1'b0, {5'd0, b00_q} * {5'd0, b_id_q}});
      key_d.err = 1'b0;
    end
  end

  // Stage C
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

// ===== src/hc_front.sv =====
// Front end: accepts items, pairs letters and pads odd letters with x.
module hc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [4:0]          letter_in_i,
  input  logic                separator_i,
  input  logic                message_end_i,
  input  logic                space_i,
  input  logic                busy_i,
  output logic                push_o,
  output hc_pkg::pair_t       pair_o
);

  logic            half_valid_q, half_valid_d;
  hc_pkg::letter_t half_letter_q, half_letter_d;
  hc_pkg::letter_t letter;
  logic            accept;

  assign in_ready_o = space_i & ~busy_i;
  assign accept     = in_valid_i & in_ready_o;
  assign letter     = hc_pkg::red26(letter_in_i);

  // Classify the item and build the pair it completes
  always_comb begin
    push_o        = 1'b0;
    pair_o.p0     = half_letter_q;
    pair_o.p1     = hc_pkg::PadLetter;
    pair_o.last   = 1'b0;
    half_valid_d  = half_valid_q;
    half_letter_d = half_letter_q;
    if (accept) begin
      if (separator_i) begin
        if (half_valid_q) begin
          push_o        = 1'b1;
          half_valid_d  = 1'b0;
          half_letter_d = 5'd0;
        end
      end else if (half_valid_q) begin
        push_o        = 1'b1;
        pair_o.p1     = letter;
        half_valid_d  = 1'b0;
        half_letter_d = 5'd0;
      end else begin
        half_valid_d  = 1'b1;
        half_letter_d = letter;
      end
      if (message_end_i) begin
        if (half_valid_d && !push_o) begin
          push_o    = 1'b1;
          pair_o.p0 = half_letter_d;
          pair_o.p1 = hc_pkg::PadLetter;
        end
        half_valid_d  = 1'b0;
        half_letter_d = 5'd0;
      end
      pair_o.last = message_end_i & push_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_valid_q  <= 1'b0;
      half_letter_q <= 5'd0;
    end else begin
      half_valid_q  <= half_valid_d;
      half_letter_q <= half_letter_d;
    end
  end

endmodule

// ===== src/hc_fifo.sv =====
// Two-entry pair queue between the front end and the back end.
module hc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hc_pkg::pair_t  push_data_i,
  output logic           space_o,
  input  logic           pop_i,
  output logic           pop_valid_o,
  output hc_pkg::pair_t  pop_data_o
);

  localparam int unsigned PtrW = $clog2(hc_pkg::QDepth);
  localparam int unsigned CntW = $clog2(hc_pkg::QDepth + 1);

  hc_pkg::pair_t   mem_q [hc_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign space_o     = (count_q != CntW'(hc_pkg::QDepth));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(hc_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(hc_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== src/hc_back.sv =====
// Back end: matrix product, mod-26 reduction and letter-by-letter output.
module hc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hc_pkg::key_t   key_i,
  input  logic           pop_valid_i,
  input  hc_pkg::pair_t  pop_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [4:0]     letter_out_o,
  output logic           pair_last_o,
  output logic           message_last_o,
  output logic           key_error_o
);

  localparam int unsigned SumW = hc_pkg::SumW;

  logic            s1_valid_q;
  logic [SumW-1:0] sum0_q, sum1_q;
  logic            s1_last_q, s1_err_q;

  logic            r_valid_q, r_phase_q;
  hc_pkg::letter_t r0_q, r1_q;
  logic            r_last_q, r_err_q;

  logic            out_valid_q;
  hc_pkg::letter_t out_letter_q;
  logic            out_pair_last_q, out_msg_last_q, out_err_q;

  logic            out_load, r_done, r_free, s2_load, s1_free;
  logic [SumW-1:0] m00, m01, m10, m11;

  // Stage handshakes
  assign out_load = r_valid_q & (~out_valid_q | out_ready_i);
  assign r_done   = out_load & r_phase_q;
  assign r_free   = ~r_valid_q | r_done;
  assign s2_load  = s1_valid_q & r_free;
  assign s1_free  = ~s1_valid_q | r_free;
  assign pop_o    = pop_valid_i & s1_free;

  // Matrix times pair
  always_comb begin
    m00 = {6'd0, key_i.e00} * {6'd0, pop_data_i.p0};
    m01 = {6'd0, key_i.e01} * {6'd0, pop_data_i.p1};
    m10 = {6'd0, key_i.e10} * {6'd0, pop_data_i.p0};
    m11 = {6'd0, key_i.e11} * {6'd0, pop_data_i.p1};
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sum0_q    <= m00 + m01;
      sum1_q    <= m10 + m11;
      s1_last_q <= pop_data_i.last;
      s1_err_q  <= key_i.err;
    end
    if (s2_load) begin
      r0_q     <= hc_pkg::mod26(sum0_q);
      r1_q     <= hc_pkg::mod26(sum1_q);
      r_last_q <= s1_last_q;
      r_err_q  <= s1_err_q;
    end
    if (out_load) begin
      out_letter_q    <= r_phase_q ? r1_q : r0_q;
      out_pair_last_q <= r_phase_q;
      out_msg_last_q  <= r_phase_q & r_last_q;
      out_err_q       <= r_err_q;
    end
  end

  // Stage valid bits and letter phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      r_valid_q   <= 1'b0;
      r_phase_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        r_valid_q <= 1'b1;
        r_phase_q <= 1'b0;
      end else begin
        if (r_done) begin
          r_valid_q <= 1'b0;
        end
        if (out_load) begin
          r_phase_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign letter_out_o   = out_letter_q;
  assign pair_last_o    = out_pair_last_q;
  assign message_last_o = out_msg_last_q;
  assign key_error_o    = out_err_q;

endmodule

// ===== src/hill_cipher_2x2_mod26.sv =====
// Top level of the 2x2 Hill cipher over a 26-letter alphabet.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   input    | in_valid_i/in_ready_o   | letter_in_i, separator_i, message_end_i
//   output   | out_valid_o/out_ready_i | letter_out_o, pair_last_o, message_last_o,
//            |                        | key_error_o
//   config   | APB psel/penable        | paddr, pwdata, prdata (pready tied high)
//
// An item is taken whenever in_ready_o is high; each completed pair leaves as two
// letters, the second as soon as the first is taken, so the output port sets the pace.
// After the item that completes a pair is accepted, the pair passes the pair queue,
// the sum, mod-26 and output registers before its first letter shows.
// The derived key matrix settles through stages A, B and C after reset or a
// register write; input ready stays low until it has.
// The two-entry pair queue lets input go on while the output stalls, until it fills.
module hill_cipher_2x2_mod26 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  letter_in_i,
  input  logic        separator_i,
  input  logic        message_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  letter_out_o,
  output logic        pair_last_o,
  output logic        message_last_o,
  output logic        key_error_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hc_pkg::key_t  key;
  hc_pkg::pair_t push_pair, pop_pair;
  logic          busy, space, push, pop, pop_valid;

  assign pready = 1'b1;

  hc_key u_key (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .key_o   (key),
    .busy_o  (busy)
  );

  hc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .letter_in_i   (letter_in_i),
    .separator_i   (separator_i),
    .message_end_i (message_end_i),
    .space_i       (space),
    .busy_i        (busy),
    .push_o        (push),
    .pair_o        (push_pair)
  );

  hc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_pair),
    .space_o     (space),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_pair)
  );

  hc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_i          (key),
    .pop_valid_i    (pop_valid),
    .pop_data_i     (pop_pair),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .letter_out_o   (letter_out_o),
    .pair_last_o    (pair_last_o),
    .message_last_o (message_last_o),
    .key_error_o    (key_error_o)
  );

  // Message end only ever marks the second letter of a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_last_o |-> pair_last_o)
    else $error("message_last without pair_last");

  // A bad key gives zero letters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_error_o |-> letter_out_o == 5'd0)
    else $error("nonzero letter with key error");

  // The second letter of a pair follows the first at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !pair_last_o |=> out_valid_o && pair_last_o)
    else $error("second letter of pair missing");

  // Output letters stay inside the alphabet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> letter_out_o < 5'd26)
    else $error("letter out of range");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the 2x2 mod-26 Hill cipher: handshaked items checked against a cipher predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Modulus     = 26;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned PhaseItems  = 140;
  localparam int unsigned NumPhases   = 13;
  localparam int unsigned LongHold    = 80;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    hc_pkg::letter_t letter;
    logic            sep;
    logic            msg_end;
  } stim_t;

  typedef struct packed {
    hc_pkg::letter_t letter;
    logic            pair_last;
    logic            msg_last;
    logic            key_err;
  } cipher_out_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [4:0]  letter_in   = '0;
  logic        separator   = 1'b0;
  logic        message_end = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [4:0]  letter_out;
  logic        pair_last;
  logic        message_last;
  logic        key_error;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the registers and the half-pair state
  hc_pkg::letter_t key_m [4] = '{5'd9, 5'd4, 5'd5, 5'd7};
  logic            decrypt_on     = 1'b0;
  logic            pending_valid  = 1'b0;
  hc_pkg::letter_t pending_letter = '0;

  stim_t       stim_q [$];
  cipher_out_t expected_q [$];
  stim_t       cur_item;
  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt      = 0;
  bit          idle_on      = 1'b1;
  bit          rx_hold_req  = 1'b0;
  int unsigned tx_gap       = 0;
  int unsigned rx_stall     = 0;
  int unsigned quiet_cycles = 0;

  hill_cipher_2x2_mod26 dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .letter_in_i    (letter_in),
    .separator_i    (separator),
    .message_end_i  (message_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .letter_out_o   (letter_out),
    .pair_last_o    (pair_last),
    .message_last_o (message_last),
    .key_error_o    (key_error),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Multiplicative inverse mod 26, zero when the value has none
  function automatic int unsigned inverse_mod26(input int unsigned d);
    for (int unsigned x = 1; x < Modulus; x++) begin
      if ((d * x) % Modulus == 1) return x;
    end
    return 0;
  endfunction

  // Encrypt or decrypt one letter pair with the current key
  function automatic void cipher_pair(input int unsigned p0, input int unsigned p1,
                                      output cipher_out_t first, output cipher_out_t second);
    int unsigned m00, m01, m10, m11, det, dinv, r0, r1;
    logic bad;
    m00 = key_m[0] % Modulus;
    m01 = key_m[1] % Modulus;
    m10 = key_m[2] % Modulus;
    m11 = key_m[3] % Modulus;
    bad = 1'b0;
    r0  = 0;
    r1  = 0;
    if (decrypt_on) begin
      det  = (m00 * m11 + Modulus * Modulus - m01 * m10) % Modulus;
      dinv = inverse_mod26(det);
      if (dinv == 0) begin
        bad = 1'b1;
      end else begin
        r0 = (((m11 * dinv) % Modulus) * p0
              + ((((Modulus - m01) % Modulus) * dinv) % Modulus) * p1) % Modulus;
        r1 = (((((Modulus - m10) % Modulus) * dinv) % Modulus) * p0
              + ((m00 * dinv) % Modulus) * p1) % Modulus;
      end
    end else begin
      r0 = (m00 * p0 + m01 * p1) % Modulus;
      r1 = (m10 * p0 + m11 * p1) % Modulus;
    end
    first  = '{letter: hc_pkg::letter_t'(r0), pair_last: 1'b0, msg_last: 1'b0, key_err: bad};
    second = '{letter: hc_pkg::letter_t'(r1), pair_last: 1'b1, msg_last: 1'b0, key_err: bad};
  endfunction

  // Advance the pairing state by one item and queue the letters it releases
  function automatic void predict_item(input stim_t it);
    cipher_out_t first, second;
    bit          made;
    int unsigned ltr;
    made = 1'b0;
    ltr  = it.letter % Modulus;
    if (it.sep) begin
      if (pending_valid) begin
        cipher_pair(pending_letter, hc_pkg::PadLetter, first, second);
        made          = 1'b1;
        pending_valid = 1'b0;
      end
    end else if (pending_valid) begin
      cipher_pair(pending_letter, ltr, first, second);
      made          = 1'b1;
      pending_valid = 1'b0;
    end else begin
      pending_valid  = 1'b1;
      pending_letter = hc_pkg::letter_t'(ltr);
    end
    if (it.msg_end) begin
      if (pending_valid) begin
        cipher_pair(pending_letter, hc_pkg::PadLetter, first, second);
        made = 1'b1;
      end
      pending_valid  = 1'b0;
      pending_letter = '0;
      if (made) second.msg_last = 1'b1;
    end
    if (made) begin
      expected_q.push_back(first);
      expected_q.push_back(second);
    end
  endfunction

  function automatic void add_item(input hc_pkg::letter_t l, input logic s, input logic e);
    stim_q.push_back('{letter: l, sep: s, msg_end: e});
    queued_cnt++;
  endfunction

  // Mostly words of letters, with breaks, message ends and stray letter codes
  function automatic void add_random_items(input int unsigned count);
    int unsigned sel;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 72) begin
        add_item(hc_pkg::letter_t'($urandom_range(0, 25)), 1'b0, 1'b0);
      end else if (sel < 76) begin
        add_item(hc_pkg::letter_t'($urandom_range(26, 31)), 1'b0, 1'b0);
      end else if (sel < 86) begin
        add_item(hc_pkg::letter_t'($urandom_range(0, 31)), 1'b1, 1'b0);
      end else if (sel < 94) begin
        add_item(hc_pkg::letter_t'($urandom_range(0, 31)), 1'b0, 1'b1);
      end else begin
        add_item(hc_pkg::letter_t'($urandom_range(0, 31)), 1'b1,
                 1'($urandom_range(0, 1)));
      end
    end
  endfunction

  function automatic void note_mismatch(input string what, input cipher_out_t want,
                                        input cipher_out_t got);
    err_cnt++;
    if (err_cnt <= MaxReports) begin
      $display("%t %s: expected letter %0d pair_last %0b message_last %0b key_error %0b,",
               $realtime, what, want.letter, want.pair_last, want.msg_last, want.key_err);
      $display("    got letter %0d pair_last %0b message_last %0b key_error %0b",
               got.letter, got.pair_last, got.msg_last, got.key_err);
    end
  endfunction

  // Write one register through a setup and an access cycle
  task automatic write_reg(input logic [2:0] idx, input logic [4:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == hc_pkg::RegDecrypt) begin
      decrypt_on = value[0];
    end else begin
      key_m[idx[1:0]] = value;
    end
  endtask

  task automatic load_key(input logic [4:0] k00, input logic [4:0] k01,
                          input logic [4:0] k10, input logic [4:0] k11, input logic dec);
    write_reg(hc_pkg::RegK00, k00);
    write_reg(hc_pkg::RegK01, k01);
    write_reg(hc_pkg::RegK10, k10);
    write_reg(hc_pkg::RegK11, k11);
    write_reg(hc_pkg::RegDecrypt, {4'd0, dec});
  endtask

  // Hold until every queued item is taken and every expected letter is out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_cnt != queued_cnt || expected_q.size() != 0);
  endtask

  // Drive items from the pending queue, predicting each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(stim_t'({letter_in, separator, message_end}));
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur_item    = stim_q.pop_front();
          letter_in   <= cur_item.letter;
          separator   <= cur_item.sep;
          message_end <= cur_item.msg_end;
          in_valid    <= 1'b1;
          if (idle_on && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Take result letters, check them in order, and stall the output at random
  always @(posedge clk_i or negedge rst_ni) begin
    cipher_out_t got, want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {letter_out, pair_last, message_last, key_error};
        if (expected_q.size() == 0) begin
          note_mismatch("unexpected letter", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.letter !== want.letter || got.pair_last !== want.pair_last ||
              got.msg_last !== want.msg_last || got.key_err !== want.key_err) begin
            note_mismatch("wrong letter", want, got);
          end
        end
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_stall    = LongHold;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        rx_stall = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items with the reset key in encrypt mode
    @(negedge clk_i);
    add_item(5'd0, 1'b0, 1'b0);
    add_item(5'd25, 1'b0, 1'b0);
    add_item(5'd31, 1'b0, 1'b0);   // stray codes reduce mod 26
    add_item(5'd26, 1'b0, 1'b0);
    add_item(5'd17, 1'b1, 1'b0);   // break with nothing pending is dropped
    add_item(5'd7, 1'b0, 1'b0);
    add_item(5'd12, 1'b1, 1'b0);   // break pads the pending letter
    add_item(5'd11, 1'b0, 1'b0);
    add_item(5'd3, 1'b0, 1'b1);    // letter completes the pair and ends the message
    add_item(5'd9, 1'b1, 1'b1);    // end with nothing pending gives no letters
    add_item(5'd4, 1'b0, 1'b1);    // lone letter at the end is padded
    add_item(5'd2, 1'b0, 1'b0);
    add_item(5'd30, 1'b1, 1'b1);   // break pads, end marks the last letter
    add_item(5'd19, 1'b0, 1'b0);
    add_item(5'd21, 1'b0, 1'b0);
    add_item(5'd15, 1'b0, 1'b0);
    add_item(5'd0, 1'b0, 1'b1);
    wait_drained();

    // Run phases, each with its own key and mode
    for (int p = 0; p < NumPhases; p++) begin
      repeat (DrainCycles) @(posedge clk_i);
      case (p)
        0:       load_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b0);
        1:       load_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b1);
        2:       load_key(5'd9, 5'd4, 5'd5, 5'd7, 1'b1);
        3:       load_key(5'd0, 5'd0, 5'd0, 5'd0, 1'b1);
        4:       load_key(5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
        5:       load_key(5'd25, 5'd25, 5'd25, 5'd25, 1'b0);
        6:       load_key(5'd31, 5'd31, 5'd31, 5'd31, 1'b1);
        7:       load_key(5'd27, 5'd26, 5'd26, 5'd27, 1'b1);
        8:       load_key(5'd2, 5'd4, 5'd6, 5'd8, 1'b1);
        12:      load_key(5'd5, 5'd17, 5'd8, 5'd3, 1'b1);
        default: load_key(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                          5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)));
      endcase
      @(negedge clk_i);
      if (p == 2) rx_hold_req = 1'b1;
      if (p == NumPhases - 1) idle_on = 1'b0;
      add_random_items(PhaseItems);
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
